// ===== sv/sct_pkg.sv =====
// package: token codes, queue sizing and shared types for the source char tokenizer
`timescale 1ns / 1ps

package sct_pkg;

    // token kinds
    localparam logic [3:0] KIND_KEYWORD  = 4'd0;
    localparam logic [3:0] KIND_IDENT    = 4'd1;
    localparam logic [3:0] KIND_NUMBER   = 4'd2;
    localparam logic [3:0] KIND_STRING   = 4'd3;
    localparam logic [3:0] KIND_PLUS     = 4'd4;
    localparam logic [3:0] KIND_MINUS    = 4'd5;
    localparam logic [3:0] KIND_STAR     = 4'd6;
    localparam logic [3:0] KIND_SLASH    = 4'd7;
    localparam logic [3:0] KIND_EQ       = 4'd8;
    localparam logic [3:0] KIND_EQEQ     = 4'd9;
    localparam logic [3:0] KIND_LPAREN   = 4'd10;
    localparam logic [3:0] KIND_RPAREN   = 4'd11;
    localparam logic [3:0] KIND_SEMI     = 4'd12;
    localparam logic [3:0] KIND_END      = 4'd13;
    localparam logic [3:0] KIND_UNREC    = 4'd14;
    localparam logic [3:0] KIND_UNCLOSED = 4'd15;

    // token queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    localparam int QCNT_W      = 3;

    // one finished token
    typedef struct packed {
        logic [3:0] kind;
        logic [7:0] len;
    } tok_t;

    // tokens caused by one item: first always present, second when two is set
    typedef struct packed {
        logic two;
        tok_t t0;
        tok_t t1;
    } tok_pair_t;

endpackage

// ===== sv/sct_front.sv =====
// front part: accepts bytes, keeps lexer state and builds the token pair of each item
`timescale 1ns / 1ps

module sct_front #(
    parameter int LEN_BITS = 8
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [7:0]        s_ch,
    input  logic              s_end_of_source,
    input  logic              q_full,
    output logic              q_push,
    output sct_pkg::tok_pair_t q_data
);
    import sct_pkg::*;

    localparam logic [2:0] MODE_IDLE    = 3'd0;
    localparam logic [2:0] MODE_IDENT   = 3'd1;
    localparam logic [2:0] MODE_NUMBER  = 3'd2;
    localparam logic [2:0] MODE_STRING  = 3'd3;
    localparam logic [2:0] MODE_SLASH   = 3'd4;
    localparam logic [2:0] MODE_EQ      = 3'd5;
    localparam logic [2:0] MODE_COMMENT = 3'd6;

    localparam logic [23:0] KW_LET = 24'h6C6574;
    localparam logic [23:0] KW_VAR = 24'h766172;
    localparam logic [23:0] KW_IF  = 24'h006966;

    logic [2:0]          mode_reg, mode_next;
    logic [LEN_BITS-1:0] run_reg, run_next;
    logic [23:0]         prefix_reg, prefix_next;

    logic        accept;
    logic        eos;
    logic        is_alpha, is_digit, is_space;
    logic [16:0] run_wide;
    logic [7:0]  run_sat;
    logic        is_keyword;
    logic        flush_vld, fresh, idle_vld;
    tok_t        flush_tok, idle_tok;

    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;
    assign eos     = s_end_of_source || (s_ch == 8'd0);

    // byte classes
    always_comb begin
        is_alpha = s_ch inside {[8'h61:8'h7A], [8'h41:8'h5A]};
        is_digit = s_ch inside {[8'h30:8'h39]};
        is_space = s_ch inside {8'h20, [8'h09:8'h0D]};
    end

    // run length widened for compares, and clipped to the output width
    assign run_wide   = 17'(run_reg);
    assign run_sat    = (run_wide > 17'd255) ? 8'hFF : run_wide[7:0];
    assign is_keyword = ((run_wide == 17'd3) && ((prefix_reg == KW_LET) ||
                                                 (prefix_reg == KW_VAR))) ||
                        ((run_wide == 17'd2) && (prefix_reg == KW_IF));

    // token that closes the pending run, and state update
    always_comb begin
        mode_next   = mode_reg;
        run_next    = run_reg;
        prefix_next = prefix_reg;
        flush_vld   = 1'b0;
        flush_tok   = '{kind: KIND_IDENT, len: run_sat};
        fresh       = 1'b0;
        if (eos) begin
            mode_next   = MODE_IDLE;
            run_next    = '0;
            prefix_next = '0;
            case (mode_reg)
                MODE_IDENT: begin
                    flush_vld = 1'b1;
                    flush_tok = '{kind: is_keyword ? KIND_KEYWORD : KIND_IDENT,
                                  len: run_sat};
                end
                MODE_NUMBER: begin
                    flush_vld = 1'b1;
                    flush_tok = '{kind: KIND_NUMBER, len: run_sat};
                end
                MODE_STRING: begin
                    flush_vld = 1'b1;
                    flush_tok = '{kind: KIND_UNCLOSED, len: run_sat};
                end
                MODE_SLASH: begin
                    flush_vld = 1'b1;
                    flush_tok = '{kind: KIND_SLASH, len: 8'd1};
                end
                MODE_EQ: begin
                    flush_vld = 1'b1;
                    flush_tok = '{kind: KIND_EQ, len: 8'd1};
                end
                default: begin
                end
            endcase
        end else begin
            case (mode_reg)
                MODE_IDENT, MODE_NUMBER: begin
                    if (is_digit || (is_alpha && (mode_reg == MODE_IDENT))) begin
                        if (run_wide < 17'd3) prefix_next = {prefix_reg[15:0], s_ch};
                        if (run_reg != '1) run_next = run_reg + 1'b1;
                    end else begin
                        flush_vld = 1'b1;
                        fresh     = 1'b1;
                        if (mode_reg == MODE_NUMBER) begin
                            flush_tok = '{kind: KIND_NUMBER, len: run_sat};
                        end else begin
                            flush_tok = '{kind: is_keyword ? KIND_KEYWORD : KIND_IDENT,
                                          len: run_sat};
                        end
                    end
                end
                MODE_STRING: begin
                    if (s_ch == 8'h22) begin
                        flush_vld   = 1'b1;
                        flush_tok   = '{kind: KIND_STRING, len: run_sat};
                        mode_next   = MODE_IDLE;
                        run_next    = '0;
                        prefix_next = '0;
                    end else if (is_alpha || is_digit) begin
                        if (run_wide < 17'd3) prefix_next = {prefix_reg[15:0], s_ch};
                        if (run_reg != '1) run_next = run_reg + 1'b1;
                    end else begin
                        flush_vld = 1'b1;
                        flush_tok = '{kind: KIND_UNCLOSED, len: run_sat};
                        fresh     = 1'b1;
                    end
                end
                MODE_SLASH: begin
                    if (s_ch == 8'h2F) begin
                        mode_next   = MODE_COMMENT;
                        run_next    = '0;
                        prefix_next = '0;
                    end else begin
                        flush_vld = 1'b1;
                        flush_tok = '{kind: KIND_SLASH, len: 8'd1};
                        fresh     = 1'b1;
                    end
                end
                MODE_EQ: begin
                    flush_vld = 1'b1;
                    if (s_ch == 8'h3D) begin
                        flush_tok   = '{kind: KIND_EQEQ, len: 8'd2};
                        mode_next   = MODE_IDLE;
                        run_next    = '0;
                        prefix_next = '0;
                    end else begin
                        flush_tok = '{kind: KIND_EQ, len: 8'd1};
                        fresh     = 1'b1;
                    end
                end
                MODE_COMMENT: begin
                    if (s_ch == 8'h0A) begin
                        mode_next   = MODE_IDLE;
                        run_next    = '0;
                        prefix_next = '0;
                    end
                end
                default: begin
                    fresh = 1'b1;
                end
            endcase
        end

        // byte lexed afresh from idle
        idle_vld = 1'b0;
        idle_tok = '{kind: KIND_END, len: 8'd0};
        if (eos) begin
            idle_vld = 1'b1;
        end else if (fresh) begin
            mode_next   = MODE_IDLE;
            run_next    = '0;
            prefix_next = '0;
            idle_tok.len = 8'd1;
            case (s_ch)
                8'h2B: begin idle_vld = 1'b1; idle_tok.kind = KIND_PLUS;   end
                8'h2D: begin idle_vld = 1'b1; idle_tok.kind = KIND_MINUS;  end
                8'h2A: begin idle_vld = 1'b1; idle_tok.kind = KIND_STAR;   end
                8'h28: begin idle_vld = 1'b1; idle_tok.kind = KIND_LPAREN; end
                8'h29: begin idle_vld = 1'b1; idle_tok.kind = KIND_RPAREN; end
                8'h3B: begin idle_vld = 1'b1; idle_tok.kind = KIND_SEMI;   end
                8'h2F: mode_next = MODE_SLASH;
                8'h3D: mode_next = MODE_EQ;
                8'h22: mode_next = MODE_STRING;
                default: begin
                    if (is_alpha || is_digit) begin
                        mode_next   = is_alpha ? MODE_IDENT : MODE_NUMBER;
                        run_next    = LEN_BITS'(1);
                        prefix_next = {16'd0, s_ch};
                    end else if (!is_space) begin
                        idle_vld      = 1'b1;
                        idle_tok.kind = KIND_UNREC;
                    end
                end
            endcase
        end
    end

    // pack the item's tokens in order
    always_comb begin
        q_push = accept && (flush_vld || idle_vld);
        if (flush_vld) begin
            q_data = '{two: idle_vld, t0: flush_tok, t1: idle_tok};
        end else begin
            q_data = '{two: 1'b0, t0: idle_tok, t1: idle_tok};
        end
    end

    // lexer state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg   <= MODE_IDLE;
            run_reg    <= '0;
            prefix_reg <= '0;
        end else if (accept) begin
            mode_reg   <= mode_next;
            run_reg    <= run_next;
            prefix_reg <= prefix_next;
        end
    end

    // an end item always leaves the lexer idle and cleared
    assert property (@(posedge aclk) disable iff (!aresetn)
        accept && eos |=> (mode_reg == MODE_IDLE) && (run_reg == '0))
        else $error("lexer state not cleared after end item");

endmodule

// ===== sv/sct_queue.sv =====
// short token queue between front and back
`timescale 1ns / 1ps

module sct_queue (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               push,
    input  sct_pkg::tok_pair_t push_data,
    output logic               full,
    input  logic               pop,
    output sct_pkg::tok_pair_t pop_data,
    output logic               empty
);
    import sct_pkg::*;

    tok_pair_t         mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_reg, wr_next;
    logic [QPTR_W-1:0] rd_reg, rd_next;
    logic [QCNT_W-1:0] cnt_reg, cnt_next;

    assign full     = (cnt_reg == QCNT_W'(QUEUE_DEPTH));
    assign empty    = (cnt_reg == '0);
    assign pop_data = mem_reg[rd_reg];

    // pointer and fill count update
    always_comb begin
        wr_next  = push ? wr_reg + 1'b1 : wr_reg;
        rd_next  = pop ? rd_reg + 1'b1 : rd_reg;
        cnt_next = cnt_reg + QCNT_W'(push) - QCNT_W'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    // entry storage
    always_ff @(posedge aclk) begin
        if (push) mem_reg[wr_reg] <= push_data;
    end

    assert property (@(posedge aclk) disable iff (!aresetn) push |-> !full)
        else $error("push into full token queue");
    assert property (@(posedge aclk) disable iff (!aresetn) pop |-> !empty)
        else $error("pop from empty token queue");
    assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= QCNT_W'(QUEUE_DEPTH))
        else $error("token queue count out of range");

endmodule

// ===== sv/sct_back.sv =====
// back part: unpacks token pairs and drives the registered result channel
`timescale 1ns / 1ps

module sct_back (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               q_empty,
    input  sct_pkg::tok_pair_t q_data,
    output logic               q_pop,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [3:0]         m_token_kind,
    output logic [7:0]         m_token_length,
    output logic               m_last_of_run
);
    import sct_pkg::*;

    logic out_vld_reg, out_vld_next;
    tok_t out_tok_reg, out_tok_next;
    logic out_last_reg, out_last_next;
    logic pend_vld_reg, pend_vld_next;
    tok_t pend_tok_reg, pend_tok_next;
    logic load;

    assign load = !out_vld_reg || m_ready;

    // pick the next item for the output register: held second token first
    always_comb begin
        out_vld_next  = out_vld_reg;
        out_tok_next  = out_tok_reg;
        out_last_next = out_last_reg;
        pend_vld_next = pend_vld_reg;
        pend_tok_next = pend_tok_reg;
        q_pop         = 1'b0;
        if (load) begin
            if (pend_vld_reg) begin
                out_vld_next  = 1'b1;
                out_tok_next  = pend_tok_reg;
                out_last_next = 1'b1;
                pend_vld_next = 1'b0;
            end else if (!q_empty) begin
                q_pop         = 1'b1;
                out_vld_next  = 1'b1;
                out_tok_next  = q_data.t0;
                out_last_next = !q_data.two;
                pend_vld_next = q_data.two;
                pend_tok_next = q_data.t1;
            end else begin
                out_vld_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg  <= 1'b0;
            pend_vld_reg <= 1'b0;
        end else begin
            out_vld_reg  <= out_vld_next;
            pend_vld_reg <= pend_vld_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        out_tok_reg  <= out_tok_next;
        out_last_reg <= out_last_next;
        pend_tok_reg <= pend_tok_next;
    end

    assign m_valid        = out_vld_reg;
    assign m_token_kind   = out_tok_reg.kind;
    assign m_token_length = out_tok_reg.len;
    assign m_last_of_run  = out_last_reg;

    // a held second token only exists behind a first one still on the output
    assert property (@(posedge aclk) disable iff (!aresetn)
        pend_vld_reg |-> out_vld_reg && !out_last_reg)
        else $error("second token held without first token on output");

endmodule

// ===== sv/source_char_tokenizer.sv =====
// top level: streaming source tokenizer, front lexer, token queue and output back end
//
//  channel | direction | ports                                   | carries
//  s_      | in        | s_valid s_ready s_ch s_end_of_source    | one source byte or end mark
//  m_      | out       | m_valid m_ready m_token_kind            | one finished token
//          |           | m_token_length m_last_of_run            |
//
// one byte is taken each cycle while the four-entry token queue has room.
// an item yields zero, one or two tokens; the output register sends one token a cycle while
// m_ready is high, so two-token items drain at half rate and the queue absorbs bursts.
// first token of an item passes through the token queue and the output register to m_valid.
// aresetn is synchronous, active low, and leaves the lexer idle with an empty queue.
// a stall on m_ready backs up through the queue to s_ready; lexing never stalls otherwise.
`timescale 1ns / 1ps

module source_char_tokenizer #(
    parameter int LEN_BITS = 8
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_ch,
    input  logic       s_end_of_source,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [3:0] m_token_kind,
    output logic [7:0] m_token_length,
    output logic       m_last_of_run
);
    import sct_pkg::*;

    logic      q_full, q_empty, q_push, q_pop;
    tok_pair_t q_wdata, q_rdata;

    sct_front #(
        .LEN_BITS(LEN_BITS)
    ) u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_ch           (s_ch),
        .s_end_of_source(s_end_of_source),
        .q_full         (q_full),
        .q_push         (q_push),
        .q_data         (q_wdata)
    );

    sct_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_data(q_wdata),
        .full     (q_full),
        .pop      (q_pop),
        .pop_data (q_rdata),
        .empty    (q_empty)
    );

    sct_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .q_empty       (q_empty),
        .q_data        (q_rdata),
        .q_pop         (q_pop),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_token_kind  (m_token_kind),
        .m_token_length(m_token_length),
        .m_last_of_run (m_last_of_run)
    );

endmodule

// ===== verif/source_char_tokenizer_tb.sv =====
// testbench: source char tokenizer checked against a token predictor under random flow control
`timescale 1ns / 1ps

module source_char_tokenizer_tb;

    import sct_pkg::*;

    localparam int         CYCLE_LIMIT = 300000;
    localparam int         RANDOM_ITEMS = 1400;
    localparam logic [7:0] RUN_MAX = 8'hFF;
    localparam logic [7:0] CH_NEWLINE = 8'h0A;
    localparam logic [23:0] WORD_LET = "let";
    localparam logic [23:0] WORD_VAR = "var";
    localparam logic [23:0] WORD_IF = "if";

    // lexer modes of the predictor
    typedef enum logic [2:0] {
        LEX_IDLE    = 3'd0,
        LEX_IDENT   = 3'd1,
        LEX_NUMBER  = 3'd2,
        LEX_STRING  = 3'd3,
        LEX_SLASH   = 3'd4,
        LEX_EQ      = 3'd5,
        LEX_COMMENT = 3'd6
    } lex_mode_e;

    typedef struct packed {
        logic [3:0] kind;
        logic [7:0] length;
        logic       last;
    } exp_token_t;

    typedef struct packed {
        logic [7:0] ch;
        logic       eos;
        logic       hold;
    } src_item_t;

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    logic [7:0] s_ch = 8'd0;
    logic       s_end_of_source = 1'b0;
    logic       m_valid;
    logic       m_ready = 1'b0;
    logic [3:0] m_token_kind;
    logic [7:0] m_token_length;
    logic       m_last_of_run;

    source_char_tokenizer dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_ch            (s_ch),
        .s_end_of_source (s_end_of_source),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_token_kind    (m_token_kind),
        .m_token_length  (m_token_length),
        .m_last_of_run   (m_last_of_run)
    );

    // predictor state
    lex_mode_e   lex_mode = LEX_IDLE;
    logic [7:0]  run_count = 8'd0;
    logic [23:0] word_head = 24'd0;

    src_item_t   source_bytes[$];
    exp_token_t  expected_tokens[$];
    src_item_t   next_item;
    exp_token_t  oldest_token;

    int unsigned items_total = 0;
    int unsigned items_accepted = 0;
    int unsigned mismatches = 0;
    int unsigned cycle_count = 0;
    int unsigned burst_left = 0;
    int unsigned gap_left = 0;
    int unsigned stall_step = 0;
    logic [15:0] ready_pattern = 16'hFFFF;

    string word_list[11] = '{"let", "var", "if", "le", "lets", "iF", "va", "i", "vars",
                             "If", "LET"};
    string op_chars = "+-*();/=";

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // character classes
    function automatic bit is_letter(logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic bit is_digit(logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic exp_token_t token_of(logic [3:0] k, logic [7:0] n);
        exp_token_t t;
        t.kind   = k;
        t.length = n;
        t.last   = 1'b0;
        return t;
    endfunction

    function automatic logic [3:0] ident_kind();
        if ((run_count == 8'd3 && (word_head == WORD_LET || word_head == WORD_VAR)) ||
            (run_count == 8'd2 && word_head == WORD_IF))
            return KIND_KEYWORD;
        return KIND_IDENT;
    endfunction

    task automatic clear_run(input lex_mode_e mode);
        lex_mode  = mode;
        run_count = 8'd0;
        word_head = 24'd0;
    endtask

    // keep the first three characters, count saturates
    task automatic extend_run(input logic [7:0] c);
        if (run_count < 8'd3) word_head = {word_head[15:0], c};
        if (run_count != RUN_MAX) run_count = run_count + 8'd1;
    endtask

    // lex one accepted item and queue the tokens it finishes
    task automatic predict_tokens(input logic [7:0] c, input logic eos_in);
        exp_token_t toks[$];
        bit relex;
        relex = 1'b0;
        if (eos_in || c == 8'd0) begin
            case (lex_mode)
                LEX_IDENT:  toks = {toks, token_of(ident_kind(), run_count)};
                LEX_NUMBER: toks = {toks, token_of(KIND_NUMBER, run_count)};
                LEX_STRING: toks = {toks, token_of(KIND_UNCLOSED, run_count)};
                LEX_SLASH:  toks = {toks, token_of(KIND_SLASH, 8'd1)};
                LEX_EQ:     toks = {toks, token_of(KIND_EQ, 8'd1)};
                default: ;
            endcase
            toks = {toks, token_of(KIND_END, 8'd0)};
            clear_run(LEX_IDLE);
        end else begin
            case (lex_mode)
                LEX_IDENT: begin
                    if (is_letter(c) || is_digit(c)) begin
                        extend_run(c);
                    end else begin
                        toks = {toks, token_of(ident_kind(), run_count)};
                        relex = 1'b1;
                    end
                end
                LEX_NUMBER: begin
                    if (is_digit(c)) begin
                        extend_run(c);
                    end else begin
                        toks = {toks, token_of(KIND_NUMBER, run_count)};
                        relex = 1'b1;
                    end
                end
                LEX_STRING: begin
                    if (c == "\"") begin
                        toks = {toks, token_of(KIND_STRING, run_count)};
                        clear_run(LEX_IDLE);
                    end else if (is_letter(c) || is_digit(c)) begin
                        extend_run(c);
                    end else begin
                        toks = {toks, token_of(KIND_UNCLOSED, run_count)};
                        relex = 1'b1;
                    end
                end
                LEX_SLASH: begin
                    if (c == "/") begin
                        clear_run(LEX_COMMENT);
                    end else begin
                        toks = {toks, token_of(KIND_SLASH, 8'd1)};
                        relex = 1'b1;
                    end
                end
                LEX_EQ: begin
                    if (c == "=") begin
                        toks = {toks, token_of(KIND_EQEQ, 8'd2)};
                        clear_run(LEX_IDLE);
                    end else begin
                        toks = {toks, token_of(KIND_EQ, 8'd1)};
                        relex = 1'b1;
                    end
                end
                LEX_COMMENT: begin
                    if (c == CH_NEWLINE) clear_run(LEX_IDLE);
                end
                default: relex = 1'b1;
            endcase
            // the terminating byte starts afresh from idle
            if (relex) begin
                clear_run(LEX_IDLE);
                case (c)
                    "+":  toks = {toks, token_of(KIND_PLUS, 8'd1)};
                    "-":  toks = {toks, token_of(KIND_MINUS, 8'd1)};
                    "*":  toks = {toks, token_of(KIND_STAR, 8'd1)};
                    "(":  toks = {toks, token_of(KIND_LPAREN, 8'd1)};
                    ")":  toks = {toks, token_of(KIND_RPAREN, 8'd1)};
                    ";":  toks = {toks, token_of(KIND_SEMI, 8'd1)};
                    "/":  lex_mode = LEX_SLASH;
                    "=":  lex_mode = LEX_EQ;
                    "\"": lex_mode = LEX_STRING;
                    default: begin
                        if (is_letter(c)) begin
                            lex_mode = LEX_IDENT;
                            extend_run(c);
                        end else if (is_digit(c)) begin
                            lex_mode = LEX_NUMBER;
                            extend_run(c);
                        end else if (!(c == " " || (c >= 8'd9 && c <= 8'd13))) begin
                            toks = {toks, token_of(KIND_UNREC, 8'd1)};
                        end
                    end
                endcase
            end
        end
        if (toks.size() > 0) toks[toks.size() - 1].last = 1'b1;
        foreach (toks[i]) expected_tokens = {expected_tokens, toks[i]};
    endtask

    // stimulus helpers
    task automatic push_byte(input logic [7:0] c, input logic e);
        src_item_t it;
        it.ch   = c;
        it.eos  = e;
        it.hold = 1'b0;
        source_bytes = {source_bytes, it};
    endtask

    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++) push_byte(s[i], 1'b0);
    endtask

    function automatic logic [7:0] rand_letter();
        int idx;
        idx = $urandom_range(0, 51);
        return (idx < 26) ? 8'("a" + idx) : 8'("A" + idx - 26);
    endfunction

    function automatic logic [7:0] rand_alnum();
        int idx;
        idx = $urandom_range(0, 61);
        if (idx < 52) return (idx < 26) ? 8'("a" + idx) : 8'("A" + idx - 26);
        return 8'("0" + idx - 52);
    endfunction

    function automatic logic [7:0] rand_blank();
        int idx;
        idx = $urandom_range(8, 13);
        return (idx == 8) ? 8'(" ") : 8'(idx);
    endfunction

    // one mostly well-formed lexeme with random content
    task automatic add_lexeme();
        int pick;
        int n;
        logic [7:0] b;
        pick = $urandom_range(0, 19);
        case (pick)
            0, 1, 2: begin
                push_byte(rand_letter(), 1'b0);
                n = $urandom_range(0, 7);
                repeat (n) push_byte(rand_alnum(), 1'b0);
            end
            3, 4: push_text(word_list[4'($urandom_range(0, 10))]);
            5, 6: begin
                n = $urandom_range(1, 6);
                repeat (n) push_byte(8'("0" + $urandom_range(0, 9)), 1'b0);
            end
            7, 8: begin
                push_byte("\"", 1'b0);
                n = $urandom_range(0, 6);
                repeat (n) push_byte(rand_alnum(), 1'b0);
                // sometimes left open for the next lexeme to break
                if ($urandom_range(0, 3) != 0) push_byte("\"", 1'b0);
            end
            9, 18, 19: push_byte(op_chars[$urandom_range(0, 7)], 1'b0);
            10: push_text("==");
            11: begin
                push_text("//");
                n = $urandom_range(0, 8);
                repeat (n) begin
                    do b = 8'($urandom_range(1, 255)); while (b == CH_NEWLINE);
                    push_byte(b, 1'b0);
                end
                if ($urandom_range(0, 3) != 0) push_byte(CH_NEWLINE, 1'b0);
            end
            12, 13: push_byte(rand_blank(), 1'b0);
            14: push_byte(8'($urandom_range(1, 255)), 1'b0);
            15: push_byte(8'($urandom_range(128, 255)), 1'b0);
            16: push_byte(8'($urandom_range(0, 255)), 1'b1);
            default: push_byte(8'd0, 1'b0);
        endcase
        if ($urandom_range(0, 2) != 0) push_byte(rand_blank(), 1'b0);
    endtask

    // stimulus, reset and end of run
    initial begin
        int unsigned directed_n;
        int unsigned lexeme_count;
        lexeme_count = 0;

        // directed: every token kind, keyword, letter after digits, string closed and broken,
        // pending slash broken by a high byte, comment open at end, zero byte as end
        push_text("var=7a(+-*);\"q\"/");
        push_byte(8'hFF, 1'b0);
        push_text("\"9\t");
        push_text("==//c");
        push_byte("A", 1'b1);
        push_text("if=");
        push_byte(8'd0, 1'b0);
        directed_n = source_bytes.size();

        while (source_bytes.size() < directed_n + RANDOM_ITEMS) begin
            case (lexeme_count)
                // runs long enough that the length may saturate
                40: begin
                    push_byte(rand_letter(), 1'b0);
                    repeat ($urandom_range(253, 262)) push_byte(rand_alnum(), 1'b0);
                    push_byte(" ", 1'b0);
                end
                120: begin
                    push_byte("\"", 1'b0);
                    repeat ($urandom_range(254, 262)) push_byte(rand_alnum(), 1'b0);
                    push_byte("\"", 1'b0);
                end
                default: add_lexeme();
            endcase
            lexeme_count++;
        end
        push_byte(8'h61, 1'b1);

        // sender waits for the token stream to drain before these
        source_bytes[directed_n].hold = 1'b1;
        source_bytes[directed_n + 700].hold = 1'b1;
        items_total = source_bytes.size();

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        while (items_accepted < items_total) @(posedge aclk);
        while (expected_tokens.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // source driver: bursts of items with random gaps
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                predict_tokens(s_ch, s_end_of_source);
                items_accepted++;
            end
            if (!s_valid || s_ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_valid <= 1'b0;
                end else if (source_bytes.size() == 0 ||
                             (source_bytes[0].hold && expected_tokens.size() != 0)) begin
                    s_valid <= 1'b0;
                end else begin
                    next_item = source_bytes.pop_front();
                    s_ch            <= next_item.ch;
                    s_end_of_source <= next_item.eos;
                    s_valid         <= 1'b1;
                    if (burst_left > 0) begin
                        burst_left--;
                    end else if ($urandom_range(0, 3) == 0) begin
                        burst_left = $urandom_range(30, 80);
                        gap_left   = 0;
                    end else begin
                        burst_left = $urandom_range(0, 12);
                        gap_left   = $urandom_range(1, 6);
                    end
                end
            end
        end
    end

    // token receiver: m_ready follows a 16-bit stall pattern that is reselected at random
    always @(posedge aclk) begin
        stall_step++;
        if (stall_step % 64 == 0) begin
            case ($urandom_range(0, 3))
                0: ready_pattern = 16'hFFFF;
                1: ready_pattern = 16'h0101;
                2: ready_pattern = 16'($urandom);
                default: ready_pattern = 16'($urandom) | 16'($urandom);
            endcase
        end
        m_ready <= ready_pattern[stall_step[3:0]];
    end

    // token monitor: compare with the oldest expected token
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (expected_tokens.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected token: kind %0d len %0d last %0b",
                             m_token_kind, m_token_length, m_last_of_run);
            end else begin
                oldest_token = expected_tokens.pop_front();
                if (m_token_kind !== oldest_token.kind ||
                    m_token_length !== oldest_token.length ||
                    m_last_of_run !== oldest_token.last) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("token mismatch: expected kind %0d len %0d last %0b, %s",
                                 oldest_token.kind, oldest_token.length, oldest_token.last,
                                 $sformatf("got kind %0d len %0d last %0b",
                                           m_token_kind, m_token_length, m_last_of_run));
                end
            end
        end
    end

    // run limit
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

endmodule
